FILE: rtl/led_flash_ramp_top_assert.svh
// assertion macros for the led flash ramp block
`ifndef LED_FLASH_RAMP_TOP_ASSERT_SVH
`define LED_FLASH_RAMP_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define LFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("led_flash_ramp assertion failed");

`define LFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("led_flash_ramp assertion failed");

`else

`define LFR_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define LFR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/lfr_pkg.sv
`default_nettype none

package lfr_pkg;

  localparam int unsigned LFR_STEP_THRESHOLD = 32;
  localparam int unsigned LVL_W = 8;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_FLASH = 1'b1;

  typedef struct packed {
    logic [LVL_W-1:0] flash_step;
    logic [LVL_W-1:0] flash_peak;
    logic             cmd;
  } lfr_item_t;

  typedef struct packed {
    logic             flash_finished;
    logic             flash_started;
    logic             output_enable;
    logic [LVL_W-1:0] pwm_level;
  } lfr_result_t;

endpackage

`default_nettype wire

FILE: rtl/lfr_quot_table.sv
`default_nettype none

// constant quotient table: level divided by the step threshold modulo 256 (by one when that is zero)
module lfr_quot_table
  import lfr_pkg::*;
#(
  parameter int unsigned STEP_THRESHOLD = LFR_STEP_THRESHOLD
) (
  input  wire logic [LVL_W-1:0] level,
  output logic      [LVL_W-1:0] quot
);

  localparam int unsigned Thr   = (STEP_THRESHOLD % 256 == 0) ? 1 : (STEP_THRESHOLD % 256);
  localparam int unsigned Depth = 1 << LVL_W;

  logic [LVL_W-1:0] tab [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_tab
    localparam logic [LVL_W-1:0] QV = LVL_W'(i / Thr);
    assign tab[i] = QV;
  end

  assign quot = tab[level];

endmodule

`default_nettype wire

FILE: rtl/lfr_core.sv
`default_nettype none

// flash state and the ramp arithmetic for one item
module lfr_core
  import lfr_pkg::*;
#(
  parameter int unsigned STEP_THRESHOLD = LFR_STEP_THRESHOLD
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire lfr_item_t   item,
  output lfr_result_t      result
);

  logic [1:0]       mode, mode_next;
  logic [LVL_W-1:0] level, level_next;
  logic [LVL_W-1:0] peak, peak_next;
  logic [LVL_W-1:0] step, step_next;

  logic [LVL_W-1:0]   quot;
  logic [2*LVL_W-1:0] prod;
  logic [LVL_W-1:0]   up_add, dn_sub, up_sum, up_val, dn_dif, dn_val;
  logic               below_thr, to_down;

  lfr_quot_table #(.STEP_THRESHOLD(STEP_THRESHOLD)) u_quot (
    .level (level),
    .quot  (quot)
  );

  assign below_thr = (quot == '0);
  assign prod      = {{LVL_W{1'b0}}, step} * {{LVL_W{1'b0}}, quot};
  assign up_add    = below_thr ? step : {prod[LVL_W-2:0], 1'b0};
  assign dn_sub    = below_thr ? step : prod[LVL_W-1:0];

  // up: bump by one when the add lands on the old level
  assign up_sum  = level + up_add;
  assign up_val  = (up_sum == level) ? up_sum + LVL_W'(1) : up_sum;
  assign to_down = (up_val < level) || (level > peak) || (up_val > peak);

  // down: drop by one on no change, clamp underflow to zero
  assign dn_dif = level - dn_sub;
  always_comb begin
    dn_val = (dn_dif == level) ? dn_dif - LVL_W'(1) : dn_dif;
    if (dn_val > level) begin
      dn_val = '0;
    end
  end

  always_comb begin
    mode_next             = mode;
    level_next            = level;
    peak_next             = peak;
    step_next             = step;
    result.flash_started  = 1'b0;
    result.flash_finished = 1'b0;
    if (item.cmd == CMD_FLASH) begin
      if (mode != MODE_UP && mode != MODE_DOWN) begin
        peak_next            = item.flash_peak;
        step_next            = item.flash_step;
        level_next           = LVL_W'(1);
        mode_next            = MODE_UP;
        result.flash_started = 1'b1;
      end
    end else begin
      case (mode)
        MODE_UP: begin
          if (to_down) begin
            mode_next = MODE_DOWN;
          end else begin
            level_next = up_val;
          end
        end
        MODE_DOWN: begin
          level_next = dn_val;
          if (dn_val == '0) begin
            mode_next             = MODE_OFF;
            result.flash_finished = 1'b1;
          end
        end
        default: begin
          mode_next  = MODE_OFF;
          level_next = '0;
        end
      endcase
    end
    result.pwm_level     = level_next;
    result.output_enable = (mode_next == MODE_UP) || (mode_next == MODE_DOWN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_OFF;
      level <= '0;
      peak  <= '0;
      step  <= '0;
    end else if (fire) begin
      mode  <= mode_next;
      level <= level_next;
      peak  <= peak_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/led_flash_ramp_top.sv
// path: input register stage, ramp logic, result register stage, then the master side
// throughput: one beat per cycle while m_tready is high, set by the single registered ramp pass
// reset: synchronous active-high rst empties both register stages and returns the channel
// to off with level, peak and step at zero
`default_nettype none

module led_flash_ramp_top
  import lfr_pkg::*;
#(
  parameter int unsigned STEP_THRESHOLD = LFR_STEP_THRESHOLD
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side: flash requests and timer ticks
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] flash_peak, [15:8] flash_step
  input  wire logic [0:0]  s_tuser,   // [0] cmd: 0 tick, 1 flash request
  // master side: one result beat per input beat
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [7:0] pwm_level, [8] output_enable,
                                      // [9] flash_started, [10] flash_finished, rest zero
);

  // input register stage
  logic        in_vld;
  lfr_item_t   in_item;

  // result register stage
  lfr_result_t res, res_reg;

  logic out_free;  // result register can take a new beat this cycle
  logic adv;       // the held input beat moves through the ramp logic
  logic s_fire;

  assign out_free = !m_tvalid || m_tready;
  assign adv      = in_vld && out_free;
  assign s_tready = !in_vld || out_free;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= s_fire || (in_vld && !adv);
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.cmd        <= s_tuser[0];
      in_item.flash_peak <= s_tdata[7:0];
      in_item.flash_step <= s_tdata[15:8];
    end
  end

  // state lives in the core and only moves when a beat passes through
  lfr_core #(.STEP_THRESHOLD(STEP_THRESHOLD)) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (adv),
    .item   (in_item),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= adv || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_reg <= res;
    end
  end

  assign m_tdata = {5'd0, res_reg};

  `include "led_flash_ramp_top_assert.svh"

  // a start always shows level one with the pin driven and no finish
  `LFR_ASSERT_IMP(a_start_shape, clk, rst, m_tvalid && m_tdata[9], m_tdata[8] && (m_tdata[7:0] == 8'd1) && !m_tdata[10])
  // a finish leaves the channel dark
  `LFR_ASSERT_IMP(a_finish_dark, clk, rst, m_tvalid && m_tdata[10], !m_tdata[8] && (m_tdata[7:0] == 8'd0))
  // pin released means level zero
  `LFR_ASSERT_IMP(a_off_zero, clk, rst, m_tvalid && !m_tdata[8], m_tdata[7:0] == 8'd0)
  // a held input beat is never dropped while the result side is stalled
  `LFR_ASSERT_NEXT(a_hold_input, clk, rst, in_vld && !adv, in_vld)

endmodule

`default_nettype wire
